>>> rtl/jsu_pkg.sv
// Shared types, codes and sizes for the JSON string unescaper.
package jsu_pkg;

    // Most result words one input byte can produce.
    localparam int MAX_RESULTS = 5;

    // Default number of decoded jobs held between the front and back parts.
    localparam int JOB_FIFO_DEPTH = 4;

    // Result kinds.
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Error codes.
    localparam logic [2:0] ERR_NONE         = 3'd0;
    localparam logic [2:0] ERR_NO_QUOTE     = 3'd1;
    localparam logic [2:0] ERR_ESC_UNTERM   = 3'd2;
    localparam logic [2:0] ERR_BAD_HEX      = 3'd3;
    localparam logic [2:0] ERR_UNKNOWN_ESC  = 3'd4;
    localparam logic [2:0] ERR_STR_UNTERM   = 3'd5;

    // Characters with a meaning in a JSON string.
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_U  = 8'h75;

    // Replacement character for broken surrogates.
    localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_BODY,
        PH_ESC,
        PH_HEX,
        PH_PAIR_BS,
        PH_PAIR_U,
        PH_PAIR_HEX,
        PH_DROP
    } phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       text_end;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic [2:0] error_code;
        logic       last;
    } out_t;

    // One result word without its last flag.
    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic [2:0] error_code;
    } entry_t;

    // All result words caused by one input byte.
    typedef struct packed {
        logic [2:0]                     count;
        entry_t [MAX_RESULTS-1:0]       entries;
    } job_t;

    typedef struct packed {
        logic [2:0]      len;
        logic [3:0][7:0] bytes;
    } utf8_t;

endpackage

>>> rtl/json_string_unescape_utf8.sv
// Top level of the streaming JSON string unescaper with UTF-8 output.
//
// The block takes the bytes of a quoted JSON string one word at a time, opening quote
// first, and gives back the decoded bytes as result words: escape letters are expanded,
// a \u code becomes its UTF-8 bytes, a valid surrogate pair becomes one four-byte code
// point and a broken surrogate becomes U+FFFD. The closing quote gives a done word and a
// fault gives an error word, after which input words are dropped up to and including the
// one flagged text_end. The last flag marks the final result word caused by one input
// word; an input word may cause no result at all or up to five. Both sides look like a
// queue: an input word is taken in the cycle it is pushed while full is low, and result
// words leave one per cycle while empty is low and pop is high. The front part decodes
// each input word combinationally into a job holding all of its result words and
// writes it into a queue of FIFO_DEPTH jobs; the back part reads the oldest job and
// hands out its words in order. Input therefore runs at one word per cycle as long as
// the queue has room, the output side runs at one word per cycle while pop is high,
// and an input word that causes several results holds the output side until all of
// them have left. Reset clears the string state and empties the queue.
module json_string_unescape_utf8
#(
    parameter int FIFO_DEPTH = jsu_pkg::JOB_FIFO_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  jsu_pkg::in_t  item,
    output logic          empty,
    input  logic          pop,
    output jsu_pkg::out_t result
);

    logic          accept;
    logic          job_valid;
    jsu_pkg::job_t job;
    jsu_pkg::job_t head;
    logic          head_empty;
    logic          head_release;

    // A word is taken whenever the job queue has room, even if results are waiting.
    assign accept = push && !full;

    jsu_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .job_valid (job_valid),
        .job       (job)
    );

    jsu_fifo
    #(
        .DEPTH (FIFO_DEPTH)
    )
    u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_valid),
        .wr_data (job),
        .rd_en   (head_release),
        .rd_data (head),
        .full    (full),
        .empty   (head_empty)
    );

    jsu_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .head_empty   (head_empty),
        .pop          (pop),
        .head_release (head_release),
        .empty        (empty),
        .result       (result)
    );

endmodule

>>> rtl/jsu_front.sv
// Front part: string state machine that turns each input byte into a job of result words.
module jsu_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  jsu_pkg::in_t  item,
    output logic          job_valid,
    output jsu_pkg::job_t job
);

    function automatic jsu_pkg::entry_t make_data(input logic [7:0] b);
        jsu_pkg::entry_t e;
        e.out_byte   = b;
        e.kind       = jsu_pkg::KIND_DATA;
        e.error_code = jsu_pkg::ERR_NONE;
        return e;
    endfunction

    function automatic jsu_pkg::entry_t make_done();
        jsu_pkg::entry_t e;
        e.out_byte   = 8'd0;
        e.kind       = jsu_pkg::KIND_DONE;
        e.error_code = jsu_pkg::ERR_NONE;
        return e;
    endfunction

    function automatic jsu_pkg::entry_t make_error(input logic [2:0] code);
        jsu_pkg::entry_t e;
        e.out_byte   = 8'd0;
        e.kind       = jsu_pkg::KIND_ERROR;
        e.error_code = code;
        return e;
    endfunction

    function automatic jsu_pkg::utf8_t utf8_encode(input logic [20:0] cp);
        jsu_pkg::utf8_t r;
        r.bytes = '0;
        if (cp < 21'h80)
        begin
            r.len      = 3'd1;
            r.bytes[0] = {1'b0, cp[6:0]};
        end
        else if (cp < 21'h800)
        begin
            r.len      = 3'd2;
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
        end
        else if (cp < 21'h10000)
        begin
            r.len      = 3'd3;
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
        end
        else
        begin
            r.len      = 3'd4;
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

    jsu_pkg::phase_t phase_reg, phase_next;
    logic [15:0]     hex_value_reg, hex_value_next;
    logic [1:0]      hex_count_reg, hex_count_next;
    logic [9:0]      high_half_reg, high_half_next;

    logic [7:0]      b;
    logic            text_end;
    logic            dig_valid;
    logic [3:0]      dig;
    logic [15:0]     hex_shift;
    logic            code_high;
    logic            code_low;
    logic [20:0]     joined_cp;
    logic            esc_known;
    logic [7:0]      esc_value;

    logic            cp_en;
    logic [20:0]     cp;
    logic            a_en;
    jsu_pkg::entry_t a_item;
    logic            b_en;
    jsu_pkg::entry_t b_item;
    logic            fin;
    jsu_pkg::utf8_t  enc;
    logic [2:0]      cp_len;

    assign b        = item.in_byte;
    assign text_end = item.text_end;

    always_comb
    begin
        dig_valid = 1'b1;
        dig       = 4'd0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            dig = 4'(b - 8'h30);
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            dig = 4'(b - 8'h57);
        end
        else if (b >= 8'h41 && b <= 8'h46)
        begin
            dig = 4'(b - 8'h37);
        end
        else
        begin
            dig_valid = 1'b0;
        end
    end

    assign hex_shift = {hex_value_reg[11:0], dig};
    assign code_high = (hex_shift[15:10] == 6'b110110);
    assign code_low  = (hex_shift[15:10] == 6'b110111);
    // 0x10000 + (high << 10) + low, where the low ten bits simply concatenate.
    assign joined_cp = {(11'(high_half_reg) + 11'd64), hex_shift[9:0]};

    always_comb
    begin
        esc_known = 1'b1;
        esc_value = b;
        unique case (b)
            jsu_pkg::CH_QUOTE:  esc_value = jsu_pkg::CH_QUOTE;
            jsu_pkg::CH_BSLASH: esc_value = jsu_pkg::CH_BSLASH;
            jsu_pkg::CH_SLASH:  esc_value = jsu_pkg::CH_SLASH;
            jsu_pkg::CH_LOW_B:  esc_value = 8'h08;
            jsu_pkg::CH_LOW_F:  esc_value = 8'h0C;
            jsu_pkg::CH_LOW_N:  esc_value = 8'h0A;
            jsu_pkg::CH_LOW_R:  esc_value = 8'h0D;
            jsu_pkg::CH_LOW_T:  esc_value = 8'h09;
            default:            esc_known = 1'b0;
        endcase
    end

    always_comb
    begin
        phase_next     = phase_reg;
        hex_value_next = hex_value_reg;
        hex_count_next = hex_count_reg;
        high_half_next = high_half_reg;
        cp_en          = 1'b0;
        cp             = jsu_pkg::CP_REPLACEMENT;
        a_en           = 1'b0;
        a_item         = make_data(b);
        b_en           = 1'b0;
        b_item         = make_error(jsu_pkg::ERR_STR_UNTERM);
        fin            = 1'b0;

        unique case (phase_reg)
            jsu_pkg::PH_WAIT:
            begin
                if (b == jsu_pkg::CH_QUOTE)
                begin
                    phase_next = jsu_pkg::PH_BODY;
                end
                else
                begin
                    a_en   = 1'b1;
                    a_item = make_error(jsu_pkg::ERR_NO_QUOTE);
                    fin    = 1'b1;
                end
            end
            jsu_pkg::PH_BODY, jsu_pkg::PH_PAIR_BS:
            begin
                if (phase_reg == jsu_pkg::PH_PAIR_BS && b == jsu_pkg::CH_BSLASH)
                begin
                    phase_next = jsu_pkg::PH_PAIR_U;
                end
                else
                begin
                    // A pending high surrogate that is not followed by a backslash
                    // is replaced, and the byte is then taken as a string byte.
                    if (phase_reg == jsu_pkg::PH_PAIR_BS)
                    begin
                        cp_en      = 1'b1;
                        phase_next = jsu_pkg::PH_BODY;
                    end
                    if (b == jsu_pkg::CH_QUOTE)
                    begin
                        a_en   = 1'b1;
                        a_item = make_done();
                        fin    = 1'b1;
                    end
                    else if (b == jsu_pkg::CH_BSLASH)
                    begin
                        phase_next = jsu_pkg::PH_ESC;
                    end
                    else
                    begin
                        a_en = 1'b1;
                    end
                end
            end
            jsu_pkg::PH_ESC, jsu_pkg::PH_PAIR_U:
            begin
                if (phase_reg == jsu_pkg::PH_PAIR_U && b == jsu_pkg::CH_LOW_U)
                begin
                    phase_next     = jsu_pkg::PH_PAIR_HEX;
                    hex_value_next = 16'd0;
                    hex_count_next = 2'd0;
                end
                else
                begin
                    cp_en      = (phase_reg == jsu_pkg::PH_PAIR_U);
                    phase_next = jsu_pkg::PH_BODY;
                    if (b == jsu_pkg::CH_LOW_U)
                    begin
                        phase_next     = jsu_pkg::PH_HEX;
                        hex_value_next = 16'd0;
                        hex_count_next = 2'd0;
                    end
                    else if (esc_known)
                    begin
                        a_en   = 1'b1;
                        a_item = make_data(esc_value);
                    end
                    else
                    begin
                        a_en   = 1'b1;
                        a_item = make_error(jsu_pkg::ERR_UNKNOWN_ESC);
                        fin    = 1'b1;
                    end
                end
            end
            jsu_pkg::PH_HEX, jsu_pkg::PH_PAIR_HEX:
            begin
                if (!dig_valid)
                begin
                    a_en   = 1'b1;
                    a_item = make_error(jsu_pkg::ERR_BAD_HEX);
                    fin    = 1'b1;
                end
                else
                begin
                    hex_value_next = hex_shift;
                    if (hex_count_reg == 2'd3)
                    begin
                        hex_count_next = 2'd0;
                        phase_next     = jsu_pkg::PH_BODY;
                        if (phase_reg == jsu_pkg::PH_HEX)
                        begin
                            if (code_high)
                            begin
                                high_half_next = hex_shift[9:0];
                                phase_next     = jsu_pkg::PH_PAIR_BS;
                            end
                            else if (code_low)
                            begin
                                cp_en = 1'b1;
                            end
                            else
                            begin
                                cp_en = 1'b1;
                                cp    = {5'd0, hex_shift};
                            end
                        end
                        else
                        begin
                            cp_en = 1'b1;
                            if (code_low)
                            begin
                                cp = joined_cp;
                            end
                        end
                    end
                    else
                    begin
                        hex_count_next = hex_count_reg + 2'd1;
                    end
                end
            end
            jsu_pkg::PH_DROP:
            begin
                if (text_end)
                begin
                    phase_next = jsu_pkg::PH_WAIT;
                end
            end
        endcase

        if (phase_reg != jsu_pkg::PH_DROP)
        begin
            if (fin)
            begin
                phase_next = text_end ? jsu_pkg::PH_WAIT : jsu_pkg::PH_DROP;
            end
            else if (text_end)
            begin
                b_en = 1'b1;
                if (phase_next == jsu_pkg::PH_ESC || phase_next == jsu_pkg::PH_PAIR_U)
                begin
                    b_item = make_error(jsu_pkg::ERR_ESC_UNTERM);
                end
                else if (phase_next == jsu_pkg::PH_HEX || phase_next == jsu_pkg::PH_PAIR_HEX)
                begin
                    b_item = make_error(jsu_pkg::ERR_BAD_HEX);
                end
                else
                begin
                    if (phase_next == jsu_pkg::PH_PAIR_BS)
                    begin
                        cp_en = 1'b1;
                        cp    = jsu_pkg::CP_REPLACEMENT;
                    end
                    b_item = make_error(jsu_pkg::ERR_STR_UNTERM);
                end
                phase_next = jsu_pkg::PH_WAIT;
            end
        end
    end

    assign enc    = utf8_encode(cp);
    assign cp_len = cp_en ? enc.len : 3'd0;

    // Result order is always: code point bytes, the byte's own word, the end-of-text error.
    always_comb
    begin
        job.count = cp_len + {2'd0, a_en} + {2'd0, b_en};
        for (int k = 0; k < jsu_pkg::MAX_RESULTS; k++)
        begin
            if (3'(k) < cp_len)
            begin
                job.entries[k] = make_data(enc.bytes[2'(k)]);
            end
            else if (3'(k) == cp_len && a_en)
            begin
                job.entries[k] = a_item;
            end
            else
            begin
                job.entries[k] = b_item;
            end
        end
    end

    assign job_valid = accept && (job.count != 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= jsu_pkg::PH_WAIT;
            hex_value_reg <= 16'd0;
            hex_count_reg <= 2'd0;
            high_half_reg <= 10'd0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            hex_value_reg <= hex_value_next;
            hex_count_reg <= hex_count_next;
            high_half_reg <= high_half_next;
        end
    end

endmodule

>>> rtl/jsu_fifo.sv
// Job queue between the front and back parts.
module jsu_fifo
#(
    parameter int DEPTH = jsu_pkg::JOB_FIFO_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  jsu_pkg::job_t wr_data,
    input  logic          rd_en,
    output jsu_pkg::job_t rd_data,
    output logic          full,
    output logic          empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    jsu_pkg::job_t    mem [DEPTH];
    jsu_pkg::job_t    rd_data_reg;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = rd_data_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
        // The head register follows the read pointer and takes a job written to that
        // slot in the same cycle straight from the write side.
        if (do_wr && wr_ptr_reg == rd_ptr_next)
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem[rd_ptr_next];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/jsu_back.sv
// Back part: hands out the words of the oldest job one per pop.
module jsu_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  jsu_pkg::job_t head,
    input  logic          head_empty,
    input  logic          pop,
    output logic          head_release,
    output logic          empty,
    output jsu_pkg::out_t result
);

    logic [2:0]      idx_reg, idx_next;
    jsu_pkg::entry_t cur;
    logic            is_last;
    logic            fire;

    assign cur     = head.entries[idx_reg];
    assign is_last = (idx_reg == (head.count - 3'd1));
    assign empty   = head_empty;
    assign fire    = pop && !head_empty;

    assign result.out_byte   = cur.out_byte;
    assign result.kind       = cur.kind;
    assign result.error_code = cur.error_code;
    assign result.last       = is_last;

    assign head_release = fire && is_last;

    always_comb
    begin
        idx_next = idx_reg;
        if (fire)
        begin
            idx_next = is_last ? 3'd0 : idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 3'd0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the streaming JSON string unescaper with UTF-8 output.
`timescale 1ns / 100ps

module testbench;

    // Long enough for the slowest correct run several times over.
    localparam int LIMIT_NS = 2_000_000;
    // Cycles to let pass once nothing is expected: a byte that is dropped or that only
    // advances the string state gives no result word, so the block may still be busy.
    localparam int SETTLE_CYCLES = 16;
    // Length of the one long receiver hold-off that fills the job queue.
    localparam int LONG_HOLD = 300;
    // Random words per idling phase.
    localparam int PHASE_WORDS = 100;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full;
    logic empty;
    jsu_pkg::in_t item = '0;
    jsu_pkg::out_t result;

    // Input words waiting to be offered, and result words still owed by the block.
    jsu_pkg::in_t pending_words[$];
    jsu_pkg::out_t expected_words[$];
    int words_queued = 0;
    int mismatch_count = 0;

    // Idling rates in percent, changed by the stimulus process between phases.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // The stimulus process flips hold_toggle to start a long hold-off on the result side;
    // the counter process below owns stall_left.
    logic hold_toggle = 1'b0;
    logic hold_seen = 1'b0;
    int stall_left = 0;

    // Decoder state of the prediction, mirroring what the block keeps between bytes.
    jsu_pkg::phase_t dec_phase = jsu_pkg::PH_WAIT;
    logic [15:0] hex_acc = '0;
    logic [1:0] hex_seen = '0;
    logic [9:0] pending_high = '0;
    // Result words caused by the byte being predicted, and whether it closed the string.
    jsu_pkg::out_t step_words[$];
    bit text_closed;

    // Bytes of the text under construction before they become input words.
    logic [7:0] text_bytes[$];

    json_string_unescape_utf8 u_top
    (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .item(item),
        .empty(empty),
        .pop(pop),
        .result(result)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction of the decoded result words.
    // ------------------------------------------------------------------

    function automatic void emit(logic [7:0] b, logic [1:0] k, logic [2:0] e);
        jsu_pkg::out_t w;
        // The block has room for a bounded number of words per input byte.
        if (step_words.size() >= jsu_pkg::MAX_RESULTS)
            return;
        w.out_byte = b;
        w.kind = k;
        w.error_code = e;
        w.last = 1'b0;
        step_words.insert(step_words.size(), w);
    endfunction

    function automatic void fail_string(logic [2:0] code);
        emit(8'h00, jsu_pkg::KIND_ERROR, code);
        text_closed = 1'b1;
    endfunction

    function automatic void emit_utf8(logic [20:0] cp);
        if (cp < 21'h80)
        begin
            emit(cp[7:0], jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
        end
        else if (cp < 21'h800)
        begin
            emit({3'b110, cp[10:6]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            emit({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
        end
        else if (cp < 21'h10000)
        begin
            emit({4'b1110, cp[15:12]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            emit({2'b10, cp[11:6]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            emit({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
        end
        else
        begin
            emit({5'b11110, cp[20:18]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            emit({2'b10, cp[17:12]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            emit({2'b10, cp[11:6]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            emit({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
        end
    endfunction

    // Value of a hex digit, or -1 for any other byte.
    function automatic int hex_value_of(logic [7:0] b);
        if (b >= "0" && b <= "9")
            return b - "0";
        if (b >= "a" && b <= "f")
            return b - "a" + 10;
        if (b >= "A" && b <= "F")
            return b - "A" + 10;
        return -1;
    endfunction

    // Shifts one digit into the code; true once the fourth digit has arrived.
    function automatic bit take_hex_digit(logic [7:0] b);
        int nib;
        nib = hex_value_of(b);
        if (nib < 0)
        begin
            fail_string(jsu_pkg::ERR_BAD_HEX);
            return 1'b0;
        end
        hex_acc = {hex_acc[11:0], nib[3:0]};
        if (hex_seen == 2'd3)
        begin
            hex_seen = '0;
            return 1'b1;
        end
        hex_seen = hex_seen + 2'd1;
        return 1'b0;
    endfunction

    function automatic void body_byte(logic [7:0] b);
        if (b == jsu_pkg::CH_QUOTE)
        begin
            emit(8'h00, jsu_pkg::KIND_DONE, jsu_pkg::ERR_NONE);
            text_closed = 1'b1;
        end
        else if (b == jsu_pkg::CH_BSLASH)
        begin
            dec_phase = jsu_pkg::PH_ESC;
        end
        else
        begin
            emit(b, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
        end
    endfunction

    function automatic void escape_letter(logic [7:0] b);
        dec_phase = jsu_pkg::PH_BODY;
        case (b)
            jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH:
                emit(b, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            jsu_pkg::CH_LOW_B: emit(8'h08, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            jsu_pkg::CH_LOW_F: emit(8'h0C, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            jsu_pkg::CH_LOW_N: emit(8'h0A, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            jsu_pkg::CH_LOW_R: emit(8'h0D, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            jsu_pkg::CH_LOW_T: emit(8'h09, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            jsu_pkg::CH_LOW_U:
            begin
                dec_phase = jsu_pkg::PH_HEX;
                hex_acc = '0;
                hex_seen = '0;
            end
            default: fail_string(jsu_pkg::ERR_UNKNOWN_ESC);
        endcase
    endfunction

    // Advances the decoder by one accepted input word and queues the words it owes.
    function automatic void predict_word(jsu_pkg::in_t w);
        logic [7:0] b;
        logic [15:0] code;
        logic [20:0] joined;
        b = w.in_byte;
        step_words.delete();
        text_closed = 1'b0;
        case (dec_phase)
            jsu_pkg::PH_WAIT:
            begin
                if (b == jsu_pkg::CH_QUOTE)
                    dec_phase = jsu_pkg::PH_BODY;
                else
                    fail_string(jsu_pkg::ERR_NO_QUOTE);
            end
            jsu_pkg::PH_BODY: body_byte(b);
            jsu_pkg::PH_ESC: escape_letter(b);
            jsu_pkg::PH_HEX:
            begin
                if (take_hex_digit(b))
                begin
                    code = hex_acc;
                    dec_phase = jsu_pkg::PH_BODY;
                    if (code >= 16'hD800 && code <= 16'hDBFF)
                    begin
                        // High half: hold it and look for a second \u code.
                        pending_high = code[9:0];
                        dec_phase = jsu_pkg::PH_PAIR_BS;
                    end
                    else if (code >= 16'hDC00 && code <= 16'hDFFF)
                    begin
                        emit_utf8(jsu_pkg::CP_REPLACEMENT);
                    end
                    else
                    begin
                        emit_utf8({5'd0, code});
                    end
                end
            end
            jsu_pkg::PH_PAIR_BS:
            begin
                if (b == jsu_pkg::CH_BSLASH)
                begin
                    dec_phase = jsu_pkg::PH_PAIR_U;
                end
                else
                begin
                    // High half left alone; the byte is then an ordinary string byte.
                    emit_utf8(jsu_pkg::CP_REPLACEMENT);
                    dec_phase = jsu_pkg::PH_BODY;
                    body_byte(b);
                end
            end
            jsu_pkg::PH_PAIR_U:
            begin
                if (b == jsu_pkg::CH_LOW_U)
                begin
                    dec_phase = jsu_pkg::PH_PAIR_HEX;
                    hex_acc = '0;
                    hex_seen = '0;
                end
                else
                begin
                    // A backslash but no \u: the letter is read as an escape letter.
                    emit_utf8(jsu_pkg::CP_REPLACEMENT);
                    escape_letter(b);
                end
            end
            jsu_pkg::PH_PAIR_HEX:
            begin
                if (take_hex_digit(b))
                begin
                    code = hex_acc;
                    dec_phase = jsu_pkg::PH_BODY;
                    if (code >= 16'hDC00 && code <= 16'hDFFF)
                    begin
                        joined = 21'h10000 + {1'b0, pending_high, 10'd0};
                        joined = joined + {5'd0, code - 16'hDC00};
                        emit_utf8(joined);
                    end
                    else
                    begin
                        // Second code is not a low half: one replacement, code dropped.
                        emit_utf8(jsu_pkg::CP_REPLACEMENT);
                    end
                end
            end
            default:
            begin
                // Dropping the rest of a text after a close or an error.
                if (w.text_end)
                    dec_phase = jsu_pkg::PH_WAIT;
                return;
            end
        endcase

        if (text_closed)
        begin
            if (w.text_end)
                dec_phase = jsu_pkg::PH_WAIT;
            else
                dec_phase = jsu_pkg::PH_DROP;
        end
        else if (w.text_end)
        begin
            // The text ran out inside the string.
            if (dec_phase == jsu_pkg::PH_ESC || dec_phase == jsu_pkg::PH_PAIR_U)
            begin
                fail_string(jsu_pkg::ERR_ESC_UNTERM);
            end
            else if (dec_phase == jsu_pkg::PH_HEX || dec_phase == jsu_pkg::PH_PAIR_HEX)
            begin
                fail_string(jsu_pkg::ERR_BAD_HEX);
            end
            else
            begin
                if (dec_phase == jsu_pkg::PH_PAIR_BS)
                    emit_utf8(jsu_pkg::CP_REPLACEMENT);
                fail_string(jsu_pkg::ERR_STR_UNTERM);
            end
            dec_phase = jsu_pkg::PH_WAIT;
        end

        if (step_words.size() != 0)
            step_words[step_words.size() - 1].last = 1'b1;
        foreach (step_words[i])
            expected_words.insert(expected_words.size(), step_words[i]);
    endfunction

    // ------------------------------------------------------------------
    // Checking of the result words.
    // ------------------------------------------------------------------

    function automatic void report_field(string field_name, logic [7:0] want, logic [7:0] got);
        mismatch_count++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field_name, want, got);
    endfunction

    function automatic void check_result(jsu_pkg::out_t got);
        jsu_pkg::out_t want;
        if (expected_words.size() == 0)
        begin
            mismatch_count++;
            $display("%0t: result word with nothing expected, expected none, actual %0h",
                     $time, got);
            return;
        end
        want = expected_words.pop_front();
        if (got.out_byte !== want.out_byte)
            report_field("out_byte", want.out_byte, got.out_byte);
        if (got.kind !== want.kind)
            report_field("kind", 8'(want.kind), 8'(got.kind));
        if (got.error_code !== want.error_code)
            report_field("error_code", 8'(want.error_code), 8'(got.error_code));
        if (got.last !== want.last)
            report_field("last", 8'(want.last), 8'(got.last));
    endfunction

    // ------------------------------------------------------------------
    // Text generation.
    // ------------------------------------------------------------------

    // Appends one byte to the text under construction.
    function automatic void add_byte(logic [7:0] b);
        text_bytes.insert(text_bytes.size(), b);
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 4'd10)
            return "0" + n;
        if ($urandom_range(1) == 0)
            return "a" + (n - 4'd10);
        return "A" + (n - 4'd10);
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSLASH);
        return b;
    endfunction

    function automatic logic [7:0] escape_char();
        case ($urandom_range(7))
            0: return jsu_pkg::CH_QUOTE;
            1: return jsu_pkg::CH_BSLASH;
            2: return jsu_pkg::CH_SLASH;
            3: return jsu_pkg::CH_LOW_B;
            4: return jsu_pkg::CH_LOW_F;
            5: return jsu_pkg::CH_LOW_N;
            6: return jsu_pkg::CH_LOW_R;
            default: return jsu_pkg::CH_LOW_T;
        endcase
    endfunction

    // Any byte that is neither a known escape letter nor u.
    function automatic logic [7:0] unknown_letter();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == jsu_pkg::CH_LOW_U || b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSLASH ||
               b == jsu_pkg::CH_SLASH || b == jsu_pkg::CH_LOW_B || b == jsu_pkg::CH_LOW_F ||
               b == jsu_pkg::CH_LOW_N || b == jsu_pkg::CH_LOW_R || b == jsu_pkg::CH_LOW_T);
        return b;
    endfunction

    function automatic logic [7:0] non_hex();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (hex_value_of(b) >= 0);
        return b;
    endfunction

    function automatic logic [15:0] high_surrogate();
        case ($urandom_range(3))
            0: return 16'hD800;
            1: return 16'hDBFF;
            default: return 16'($urandom_range(16'hDBFF, 16'hD800));
        endcase
    endfunction

    function automatic logic [15:0] low_surrogate();
        case ($urandom_range(3))
            0: return 16'hDC00;
            1: return 16'hDFFF;
            default: return 16'($urandom_range(16'hDFFF, 16'hDC00));
        endcase
    endfunction

    // A \u code from every UTF-8 length class, the class edges, or a lone low half.
    function automatic logic [15:0] bmp_code();
        case ($urandom_range(5))
            0: return 16'($urandom_range(16'h007F));
            1: return 16'($urandom_range(16'h07FF, 16'h0080));
            2: return 16'($urandom_range(16'hD7FF, 16'h0800));
            3: return 16'($urandom_range(16'hFFFF, 16'hE000));
            4:
            begin
                case ($urandom_range(5))
                    0: return 16'h0000;
                    1: return 16'h007F;
                    2: return 16'h0080;
                    3: return 16'h07FF;
                    4: return 16'h0800;
                    default: return 16'hFFFF;
                endcase
            end
            default: return low_surrogate();
        endcase
    endfunction

    // Second code after a high half that does not complete the pair.
    function automatic logic [15:0] not_low_half();
        logic [15:0] v;
        if ($urandom_range(3) == 0)
            return high_surrogate();
        do
            v = bmp_code();
        while (v >= 16'hDC00 && v <= 16'hDFFF);
        return v;
    endfunction

    function automatic void add_u(logic [15:0] v);
        add_byte(jsu_pkg::CH_BSLASH);
        add_byte(jsu_pkg::CH_LOW_U);
        add_byte(hex_char(v[15:12]));
        add_byte(hex_char(v[11:8]));
        add_byte(hex_char(v[7:4]));
        add_byte(hex_char(v[3:0]));
    endfunction

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(5))
            0: return jsu_pkg::CH_QUOTE;
            1: return jsu_pkg::CH_BSLASH;
            2: return jsu_pkg::CH_LOW_U;
            3: return hex_char(4'($urandom_range(15)));
            4: return escape_char();
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // One piece of a string body, weighted toward the surrogate handling.
    function automatic void add_element();
        int r;
        r = $urandom_range(99);
        if (r < 25)
        begin
            add_byte(plain_byte());
        end
        else if (r < 40)
        begin
            add_byte(jsu_pkg::CH_BSLASH);
            add_byte(escape_char());
        end
        else if (r < 60)
        begin
            add_u(bmp_code());
        end
        else if (r < 76)
        begin
            add_u(high_surrogate());
            add_u(low_surrogate());
        end
        else if (r < 86)
        begin
            // A high half on its own; whatever follows decides how the pair breaks.
            add_u(high_surrogate());
        end
        else if (r < 92)
        begin
            add_u(high_surrogate());
            add_u(not_low_half());
        end
        else if (r < 96)
        begin
            add_byte(jsu_pkg::CH_BSLASH);
            add_byte(unknown_letter());
        end
        else
        begin
            add_byte(jsu_pkg::CH_BSLASH);
            add_byte(jsu_pkg::CH_LOW_U);
            repeat ($urandom_range(3))
                add_byte(hex_char(4'($urandom_range(15))));
            add_byte(non_hex());
        end
    endfunction

    // Turns the text into input words, text_end on the final byte.
    function automatic void queue_text();
        jsu_pkg::in_t w;
        foreach (text_bytes[i])
        begin
            w.in_byte = text_bytes[i];
            w.text_end = (i == text_bytes.size() - 1);
            pending_words.insert(pending_words.size(), w);
        end
        words_queued += text_bytes.size();
        text_bytes.delete();
    endfunction

    function automatic void build_text();
        int r;
        int cut;
        text_bytes.delete();
        if ($urandom_range(4) == 0)
        begin
            // Noise: short runs of bytes that matter to the decoder, in any order.
            if ($urandom_range(4) != 0)
                add_byte(jsu_pkg::CH_QUOTE);
            repeat ($urandom_range(8, 1))
                add_byte(noise_byte());
        end
        else
        begin
            if ($urandom_range(29) == 0)
                add_byte(plain_byte());
            else
                add_byte(jsu_pkg::CH_QUOTE);
            repeat ($urandom_range(5))
                add_element();
            r = $urandom_range(99);
            if (r < 70)
            begin
                add_byte(jsu_pkg::CH_QUOTE);
            end
            else if (r < 82)
            begin
                // Bytes after the closing quote are dropped up to the end of the text.
                add_byte(jsu_pkg::CH_QUOTE);
                repeat ($urandom_range(3, 1))
                    add_byte(8'($urandom_range(255)));
            end
            else if (r < 94)
            begin
                // Text cut short anywhere, often inside an escape or a \u code.
                add_byte(jsu_pkg::CH_QUOTE);
                cut = $urandom_range(text_bytes.size(), 1);
                while (text_bytes.size() > cut)
                    void'(text_bytes.pop_back());
            end
            // Otherwise the string is never closed.
        end
        queue_text();
    endfunction

    // Short fixed texts: raw byte extremes, an unknown escape with trailing bytes, a lone
    // high half running into the end of text (the most words one byte can give), the
    // text ending inside an escape and inside \u digits, and an empty string.
    function automatic void load_directed();
        text_bytes = '{"A"};
        queue_text();
        text_bytes = '{jsu_pkg::CH_QUOTE, 8'h00, 8'hFF, jsu_pkg::CH_BSLASH, "q", "z"};
        queue_text();
        text_bytes = '{jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_LOW_U,
                       "D", "8", "0", "0", "x"};
        queue_text();
        text_bytes = '{jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH};
        queue_text();
        text_bytes = '{jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_LOW_U, "1"};
        queue_text();
        text_bytes = '{jsu_pkg::CH_QUOTE, jsu_pkg::CH_QUOTE};
        queue_text();
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers one word at a time and predicts each accepted word.
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            item <= '0;
        end
        else
        begin
            if (push && !full)
                predict_word(item);
            // A word on offer stays until taken; otherwise decide on the next one.
            if (!push || !full)
            begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    push <= 1'b1;
                    item <= pending_words.pop_front();
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each accepted result word and stalls at random.
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
                check_result(result);
            pop <= (stall_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Counts down the long receiver hold-off once it has been requested.
    always @(posedge clk)
    begin
        if (hold_toggle != hold_seen)
        begin
            hold_seen <= hold_toggle;
            stall_left <= LONG_HOLD;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus phases and the end of the run.
    // ------------------------------------------------------------------

    // Holds the sender back until every word is accepted and every result has come.
    task automatic wait_until_drained();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || push || expected_words.size() != 0);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    initial
    begin : stimulus
        int target;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        load_directed();
        wait_until_drained();

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    // No idling, but the receiver holds off long enough to fill the block.
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                    hold_toggle = ~hold_toggle;
                end
                1:
                begin
                    send_idle_pct = 59;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 59;
                end
                default:
                begin
                    send_idle_pct = 14;
                    recv_stall_pct = 14;
                end
            endcase
            target = words_queued + PHASE_WORDS;
            while (words_queued < target)
                build_text();
            wait_until_drained();
        end

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : watchdog
        #(LIMIT_NS);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
